// ===== hw/rtl/i2cpw_pkg.sv =====
// Shared types and codes for the serial EEPROM page-write sequencer.
package i2cpw_pkg;

  // Write cache geometry: one byte per entry, addressed by an 8-bit index.
  localparam int unsigned CacheDepth = 256;
  localparam int unsigned CacheAw    = 8;

  typedef logic [7:0]         byte_t;
  typedef logic [CacheAw-1:0] cache_addr_t;

  // Request function codes.
  localparam logic [2:0] FuncLoad    = 3'd0;
  localparam logic [2:0] FuncWrite   = 3'd1;
  localparam logic [2:0] FuncRead    = 3'd2;
  localparam logic [2:0] FuncTick    = 3'd3;
  localparam logic [2:0] FuncTxDone  = 3'd4;
  localparam logic [2:0] FuncRxDone  = 3'd5;
  localparam logic [2:0] FuncBusErr  = 3'd6;
  localparam logic [2:0] FuncInit    = 3'd7;

  // Result kinds.
  localparam logic [2:0] KindStatus  = 3'd0;
  localparam logic [2:0] KindFrame   = 3'd1;
  localparam logic [2:0] KindRdReq   = 3'd2;
  localparam logic [2:0] KindWrDone  = 3'd3;
  localparam logic [2:0] KindRdDone  = 3'd4;

  // Status codes.
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StParam     = 2'd1;
  localparam logic [1:0] StBusy      = 2'd2;
  localparam logic [1:0] StErr       = 2'd3;

  // Operation phases.
  localparam logic [2:0] PhIdle      = 3'd0;
  localparam logic [2:0] PhWriteTx   = 3'd1;
  localparam logic [2:0] PhWriteWait = 3'd2;
  localparam logic [2:0] PhReadRx    = 3'd3;
  localparam logic [2:0] PhError     = 3'd4;

  // Configuration register indexes.
  localparam logic CfgDevAddr   = 1'b0;
  localparam logic CfgWaitTicks = 1'b1;

endpackage

// ===== hw/rtl/i2cpw_cache.sv =====
// Write cache: single-port-write, registered-read byte memory.
module i2cpw_cache (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  i2cpw_pkg::cache_addr_t waddr_i,
  input  i2cpw_pkg::byte_t       wdata_i,
  input  logic                  re_i,
  input  i2cpw_pkg::cache_addr_t raddr_i,
  output i2cpw_pkg::byte_t       rdata_o
);
  import i2cpw_pkg::*;

  byte_t mem_q [CacheDepth];
  byte_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/i2c_eeprom_page_write_sequencer_top.sv =====
// Top level of the serial EEPROM page-write sequencer.
//
// Usage: requests enter on the in channel (valid/ready) and carry a function
// code with its operands. Load-byte requests fill the 256-byte write cache.
// A start-write request is checked and split at page boundaries into frames;
// each frame leaves on the out channel as an address byte followed by up to
// PAGE_BYTES data bytes read from the cache. Ticks pace the frames; a
// transmit-done event starts the wait, and receive-done and bus-error
// events end the operation. The cfg channel sets the wait tick count and
// accepts but ignores the device address; it is always ready.
// The sequencer state is registered when a request is accepted, and
// results are then loaded into the output register at one per cycle
// while the receiver takes them, paced by the single cache read port. A
// new request is taken in the cycle after the last result is loaded; a
// request without results leaves the block ready for the next request.
// Reset clears the phase, the write bookkeeping and the sequencer; the cache
// content is undefined until loaded. When the receiver stalls, the result
// holds in the output register and the sequencer waits behind it.
module i2c_eeprom_page_write_sequencer_top #(
  parameter int unsigned PAGE_BYTES = 8,
  parameter int unsigned MEM_BYTES  = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Request channel.
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] func_i,
  input  logic [7:0] mem_addr_i,
  input  logic [8:0] length_i,
  input  logic [7:0] cache_index_i,
  input  logic [7:0] data_byte_i,
  input  logic       bus_refuses_i,
  // Result channel.
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] value_o,
  output logic [8:0] count_o,
  output logic [1:0] status_o,
  output logic       busy_res_o,
  output logic       last_o,
  // Configuration channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import i2cpw_pkg::*;

  localparam int unsigned RoomW    = $clog2(PAGE_BYTES + 1);
  localparam logic [9:0]  MemLimit = 10'(MEM_BYTES);

  // Sequencer states.
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SHdr  = 3'd1;
  localparam logic [2:0] SData = 3'd2;
  localparam logic [2:0] SPre  = 3'd3;
  localparam logic [2:0] SFin  = 3'd4;

  // Operation state.
  logic [2:0] phase_q, phase_d;
  logic [7:0] wstart_q, wstart_d;
  logic [8:0] wtotal_q, wtotal_d;
  logic [8:0] wdone_q, wdone_d;
  logic [7:0] wcount_q, wcount_d;
  logic [7:0] wwait_q, wwait_d;

  // Sequencer control.
  logic [2:0] st_q, st_d;
  logic       a_pend_q, a_pend_d;
  logic       b_pend_q, b_pend_d;
  logic       out_valid_q, out_valid_d;

  // Sequencer payload.
  logic [RoomW-1:0] rem_q, rem_d;
  cache_addr_t      ptr_q, ptr_d;
  logic [7:0]       hdr_val_q, hdr_val_d;
  logic [8:0]       cnt_q, cnt_d;
  logic [7:0]       pre_addr_q, pre_addr_d;
  logic [8:0]       pre_len_q, pre_len_d;
  logic [2:0]       fin_kind_q, fin_kind_d;
  logic [1:0]       fin_st_q, fin_st_d;
  logic             busy_q, busy_d;

  // Output register.
  logic [2:0] kind_q, kind_d;
  logic [7:0] value_q, value_d;
  logic [8:0] count_q, count_d;
  logic [1:0] status_q, status_d;
  logic       busy_res_q, busy_res_d;
  logic       last_q, last_d;

  logic        acc;
  logic        out_free;
  logic        out_load;
  logic        cache_re;
  byte_t       cache_rdata;
  logic        cmd_bad;
  logic [7:0]  wc_new;

  // Frame planning signals.
  logic [7:0]       f_start;
  logic [8:0]       f_total;
  logic [8:0]       f_done;
  logic [7:0]       f_now;
  logic [8:0]       f_remain;
  logic [8:0]       f_room;
  logic [8:0]       f_n;
  logic [RoomW-1:0] room_tab [CacheDepth];

  assign acc         = in_valid_i && in_ready_o;
  assign in_ready_o  = (st_q == SIdle);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  // Room left in the page for each byte address, built at elaboration.
  for (genvar g = 0; g < CacheDepth; g++) begin : g_room
    assign room_tab[g] = RoomW'(PAGE_BYTES - (g % PAGE_BYTES));
  end

  // Next frame: a new write starts from its own operands, a tick continues.
  assign f_start  = (func_i == FuncWrite) ? mem_addr_i : wstart_q;
  assign f_total  = (func_i == FuncWrite) ? length_i : wtotal_q;
  assign f_done   = (func_i == FuncWrite) ? 9'd0 : wdone_q;
  assign f_now    = f_start + f_done[7:0];
  assign f_remain = f_total - f_done;
  assign f_room   = 9'(room_tab[f_now]);
  assign f_n      = (f_remain > f_room) ? f_room : f_remain;

  // Command range check and saturating tick count.
  assign cmd_bad = (length_i == 9'd0) ||
                   (({2'b00, mem_addr_i} + {1'b0, length_i}) > MemLimit);
  assign wc_new  = (wcount_q != 8'hFF) ? wcount_q + 8'd1 : wcount_q;

  // Configuration writes. The device address has no effect on the results,
  // so only the wait tick count is kept.
  always_comb begin
    wwait_d = wwait_q;
    if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CfgWaitTicks)) begin
      wwait_d = cfg_data_i;
    end
  end

  // Request decode at acceptance, then the result sequencer.
  always_comb begin
    phase_d    = phase_q;
    wstart_d   = wstart_q;
    wtotal_d   = wtotal_q;
    wdone_d    = wdone_q;
    wcount_d   = wcount_q;
    st_d       = st_q;
    a_pend_d   = a_pend_q;
    b_pend_d   = b_pend_q;
    rem_d      = rem_q;
    ptr_d      = ptr_q;
    hdr_val_d  = hdr_val_q;
    cnt_d      = cnt_q;
    pre_addr_d = pre_addr_q;
    pre_len_d  = pre_len_q;
    fin_kind_d = fin_kind_q;
    fin_st_d   = fin_st_q;
    busy_d     = busy_q;
    out_load   = 1'b0;
    kind_d     = kind_q;
    value_d    = value_q;
    count_d    = count_q;
    status_d   = status_q;
    busy_res_d = busy_res_q;
    last_d     = last_q;
    cache_re   = 1'b0;

    if (acc) begin
      // Frame geometry is latched for every request; used only with a frame.
      rem_d      = f_n[RoomW-1:0];
      ptr_d      = f_done[CacheAw-1:0];
      hdr_val_d  = f_now;
      cnt_d      = f_n + 9'd1;
      pre_addr_d = mem_addr_i;
      pre_len_d  = length_i;
      fin_kind_d = KindStatus;
      fin_st_d   = StOk;
      a_pend_d   = 1'b0;
      b_pend_d   = 1'b0;
      st_d       = SIdle;
      case (func_i)
        FuncWrite, FuncRead: begin
          b_pend_d = 1'b1;
          if (cmd_bad) begin
            fin_st_d = StParam;
          end else if (phase_q != PhIdle) begin
            fin_st_d = StBusy;
          end else if (func_i == FuncWrite) begin
            wstart_d = mem_addr_i;
            wtotal_d = length_i;
            wdone_d  = 9'd0;
            if (bus_refuses_i) begin
              phase_d  = PhError;
              fin_st_d = StErr;
            end else begin
              phase_d = PhWriteTx;
              wdone_d = f_n;
              st_d    = SHdr;
            end
          end else begin
            if (bus_refuses_i) begin
              phase_d  = PhError;
              fin_st_d = StErr;
            end else begin
              phase_d  = PhReadRx;
              a_pend_d = 1'b1;
            end
          end
          if (st_d == SIdle) begin
            st_d = a_pend_d ? SPre : SFin;
          end
        end
        FuncTick: begin
          if (phase_q == PhWriteWait) begin
            wcount_d = wc_new;
            if (wc_new >= wwait_q) begin
              if (wdone_q >= wtotal_q) begin
                phase_d    = PhIdle;
                b_pend_d   = 1'b1;
                fin_kind_d = KindWrDone;
                st_d       = SFin;
              end else if (bus_refuses_i) begin
                phase_d    = PhIdle;
                b_pend_d   = 1'b1;
                fin_kind_d = KindWrDone;
                fin_st_d   = StErr;
                st_d       = SFin;
              end else begin
                phase_d = PhWriteTx;
                wdone_d = wdone_q + f_n;
                st_d    = SHdr;
              end
            end
          end
        end
        FuncTxDone: begin
          if (phase_q == PhWriteTx) begin
            wcount_d = 8'd0;
            phase_d  = PhWriteWait;
          end
        end
        FuncRxDone: begin
          if (phase_q == PhReadRx) begin
            phase_d    = PhIdle;
            b_pend_d   = 1'b1;
            fin_kind_d = KindRdDone;
            st_d       = SFin;
          end
        end
        FuncBusErr: begin
          if (phase_q == PhWriteTx || phase_q == PhWriteWait) begin
            b_pend_d   = 1'b1;
            fin_kind_d = KindWrDone;
            fin_st_d   = StErr;
            st_d       = SFin;
          end else if (phase_q == PhReadRx) begin
            b_pend_d   = 1'b1;
            fin_kind_d = KindRdDone;
            fin_st_d   = StErr;
            st_d       = SFin;
          end
          phase_d = PhIdle;
        end
        FuncInit: begin
          phase_d  = PhIdle;
          wstart_d = 8'd0;
          wtotal_d = 9'd0;
          wdone_d  = 9'd0;
          wcount_d = 8'd0;
        end
        default: begin
          // Load byte goes straight to the cache and gives no result.
        end
      endcase
      busy_d = (phase_d != PhIdle);
    end else begin
      case (st_q)
        SHdr: begin
          // Address byte; fetch the first data byte behind it.
          if (out_free) begin
            out_load = 1'b1;
            kind_d   = KindFrame;
            value_d  = hdr_val_q;
            count_d  = cnt_q;
            status_d = StOk;
            last_d   = 1'b0;
            cache_re = 1'b1;
            ptr_d    = ptr_q + 1'b1;
            st_d     = SData;
          end
        end
        SData: begin
          // One cache byte per free output slot, prefetching the next.
          if (out_free) begin
            out_load = 1'b1;
            kind_d   = KindFrame;
            value_d  = cache_rdata;
            count_d  = cnt_q;
            status_d = StOk;
            last_d   = (rem_q == RoomW'(1)) && !a_pend_q && !b_pend_q;
            rem_d    = rem_q - RoomW'(1);
            if (rem_q != RoomW'(1)) begin
              cache_re = 1'b1;
              ptr_d    = ptr_q + 1'b1;
            end else if (a_pend_q) begin
              st_d = SPre;
            end else if (b_pend_q) begin
              st_d = SFin;
            end else begin
              st_d = SIdle;
            end
          end
        end
        SPre: begin
          // Read request.
          if (out_free) begin
            out_load = 1'b1;
            kind_d   = KindRdReq;
            value_d  = pre_addr_q;
            count_d  = pre_len_q;
            status_d = StOk;
            last_d   = !b_pend_q;
            a_pend_d = 1'b0;
            st_d     = b_pend_q ? SFin : SIdle;
          end
        end
        SFin: begin
          // Closing status or done result.
          if (out_free) begin
            out_load = 1'b1;
            kind_d   = fin_kind_q;
            value_d  = 8'd0;
            count_d  = 9'd0;
            status_d = fin_st_q;
            last_d   = 1'b1;
            b_pend_d = 1'b0;
            st_d     = SIdle;
          end
        end
        default: begin
          st_d = SIdle;
        end
      endcase
      if (out_load) begin
        busy_res_d = busy_q;
      end
    end
  end

  // Output valid follows loads and consumption.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and operation state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      wstart_q    <= 8'd0;
      wtotal_q    <= 9'd0;
      wdone_q     <= 9'd0;
      wcount_q    <= 8'd0;
      wwait_q     <= 8'd6;
      st_q        <= SIdle;
      a_pend_q    <= 1'b0;
      b_pend_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      wstart_q    <= wstart_d;
      wtotal_q    <= wtotal_d;
      wdone_q     <= wdone_d;
      wcount_q    <= wcount_d;
      wwait_q     <= wwait_d;
      st_q        <= st_d;
      a_pend_q    <= a_pend_d;
      b_pend_q    <= b_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    ptr_q      <= ptr_d;
    hdr_val_q  <= hdr_val_d;
    cnt_q      <= cnt_d;
    pre_addr_q <= pre_addr_d;
    pre_len_q  <= pre_len_d;
    fin_kind_q <= fin_kind_d;
    fin_st_q   <= fin_st_d;
    busy_q     <= busy_d;
    kind_q     <= kind_d;
    value_q    <= value_d;
    count_q    <= count_d;
    status_q   <= status_d;
    busy_res_q <= busy_res_d;
    last_q     <= last_d;
  end

  // Write cache. Loads are taken only while the sequencer is idle, so a load
  // never overlaps the reads of a frame.
  i2cpw_cache u_cache (
    .clk_i   (clk_i),
    .we_i    (acc && (func_i == FuncLoad)),
    .waddr_i (cache_index_i),
    .wdata_i (data_byte_i),
    .re_i    (cache_re),
    .raddr_i (ptr_q),
    .rdata_o (cache_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign count_o     = count_q;
  assign status_o    = status_q;
  assign busy_res_o  = busy_res_q;
  assign last_o      = last_q;

  // A frame never streams with no data bytes left.
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SData) |-> (rem_q != RoomW'(0)))
    else $error("frame data state with no bytes left");

  // Nothing is left pending once the sequencer is back to idle.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SIdle) |-> (!a_pend_q && !b_pend_q))
    else $error("results pending while the sequencer is idle");

  // The written byte count never passes the write length.
  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wdone_q <= wtotal_q))
    else $error("write progress beyond the write length");

  // The tick counter saturates instead of wrapping.
  a_tick_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (func_i == FuncTick) && (phase_q == PhWriteWait) && (wcount_q == 8'hFF))
    |=> (wcount_q == 8'hFF))
    else $error("wait tick counter wrapped");

endmodule
